### rtl/core/pip_pkg.sv
// Shared codes for the point-in-polygon test core.
// Used by point_in_polygon_test_core; no dependencies.
package pip_pkg;

    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_VERTEX_COUNT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_MIN_X    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_MIN_Y    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_MAX_X    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_MAX_Y    = 3'd4;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

endpackage

### rtl/core/pip_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/pip_mul.sv
// Shared difference multiplier: (a_hi - a_lo) * (b_hi - b_lo), exact.
// Used twice per polygon edge by point_in_polygon_test_core.
module pip_mul #(
    parameter int COORD_BITS = 16,
    localparam int PROD_W = 2 * (COORD_BITS + 1)
) (
    input  logic signed [COORD_BITS-1:0] a_hi,
    input  logic signed [COORD_BITS-1:0] a_lo,
    input  logic signed [COORD_BITS-1:0] b_hi,
    input  logic signed [COORD_BITS-1:0] b_lo,
    output logic signed [PROD_W-1:0]     prod
);

    logic signed [COORD_BITS:0] da;
    logic signed [COORD_BITS:0] db;

    assign da   = (COORD_BITS + 1)'(a_hi) - (COORD_BITS + 1)'(a_lo);
    assign db   = (COORD_BITS + 1)'(b_hi) - (COORD_BITS + 1)'(b_lo);
    assign prod = PROD_W'(da) * PROD_W'(db);

endmodule

### rtl/core/point_in_polygon_test_core.sv
// Point-in-polygon test by crossing number over a stored vertex list.
// Depends on pip_pkg, pip_ram, pip_mul.
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+-------------------------------------
//  in       | in_valid  | in_stall  | func, vertex_index, coord_x, coord_y
//  out      | out_valid | out_stall | inside_res
//  cfg      | cfg_we    | (none)    | cfg_index, cfg_data
//
// A vertex write is stored when accepted and the core stays idle. A query walks
// START, LOADJ, an EDGE_A/EDGE_B pair per vertex, FINAL and DONE, with the input
// stalled until IDLE again; a box-rejected or empty query goes from START to
// DONE. The cost per edge is set by the single multiplier, used once for each
// side of the crossing compare, behind the registered RAM read.
// Reset restores the register defaults; the vertex RAM is not cleared.
// A finished result sits in the output register while out_stall is high;
// new transactions are taken meanwhile, a second result waits in its state.
module point_in_polygon_test_core #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS = 16,
    localparam int IDX_BITS = $clog2(MAX_VERTICES),
    localparam int CNT_BITS = $clog2(MAX_VERTICES + 1),
    localparam int CFG_W = (COORD_BITS > CNT_BITS) ? COORD_BITS : CNT_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pip_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_W-1:0]                  cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              func,
    input  logic [IDX_BITS-1:0]               vertex_index,
    input  logic signed [COORD_BITS-1:0]      coord_x,
    input  logic signed [COORD_BITS-1:0]      coord_y,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              inside_res
);

    localparam int PROD_W = 2 * (COORD_BITS + 1);
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_LOADJ,
        ST_EDGE_A,
        ST_EDGE_B,
        ST_FINAL,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [CNT_BITS-1:0]          vcount_reg;
    logic signed [COORD_BITS-1:0] bminx_reg, bminy_reg, bmaxx_reg, bmaxy_reg;
    logic [CNT_BITS-1:0]          n_reg;
    logic [IDX_BITS-1:0]          i_reg;
    logic                         pend_reg;
    logic                         inside_reg;
    logic                         out_valid_reg;
    logic                         out_res_reg;

    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_y_reg;
    logic signed [PROD_W-1:0]     lhs_reg, rhs_reg;
    logic                         strad_reg, dypos_reg;

    logic                         in_acc;
    logic                         ram_we;
    logic [IDX_BITS-1:0]          ram_raddr;
    logic [2*COORD_BITS-1:0]      ram_rdata;
    logic signed [COORD_BITS-1:0] rd_x, rd_y;
    logic [CNT_BITS-1:0]          n_m1;
    logic [CNT_BITS-1:0]          n_eff;
    logic                         last_edge;
    logic                         box_pass;
    logic                         toggle;
    logic                         out_free;
    logic signed [COORD_BITS-1:0] op_a_hi, op_a_lo, op_b_hi, op_b_lo;
    logic signed [PROD_W-1:0]     prod;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign ram_we   = in_acc && (func == pip_pkg::FUNC_WRITE)
                      && (32'(vertex_index) < MAX_VERTICES);

    assign out_valid  = out_valid_reg;
    assign inside_res = out_res_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    assign n_m1      = n_reg - CNT_BITS'(1);
    assign n_eff     = (32'(vcount_reg) > MAX_VERTICES) ? CNT_BITS'(MAX_VERTICES) : vcount_reg;
    assign last_edge = (CNT_BITS'(i_reg) == n_m1);

    assign box_pass = (px_reg >= bminx_reg) && (px_reg <= bmaxx_reg)
                      && (py_reg >= bminy_reg) && (py_reg <= bmaxy_reg);

    // dy > 0: point left when lhs < rhs; dy < 0: when lhs > rhs
    assign toggle = strad_reg && (dypos_reg ? (lhs_reg < rhs_reg) : (lhs_reg > rhs_reg));

    always_comb
    begin
        case (state_reg)
            ST_START:  ram_raddr = n_m1[IDX_BITS-1:0];
            ST_LOADJ:  ram_raddr = '0;
            ST_EDGE_B: ram_raddr = i_reg + IDX_BITS'(1);
            default:   ram_raddr = i_reg;
        endcase
    end

    pip_ram #(
        .WIDTH(2 * COORD_BITS),
        .DEPTH(MAX_VERTICES)
    ) u_vram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (vertex_index),
        .wdata ({coord_y, coord_x}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[COORD_BITS-1:0];
    assign rd_y = ram_rdata[2*COORD_BITS-1:COORD_BITS];

    // first pass (x - xi) * (yj - yi), second pass (xj - xi) * (y - yi)
    always_comb
    begin
        if (state_reg == ST_EDGE_B)
        begin
            op_a_hi = prev_x_reg;
            op_a_lo = cur_x_reg;
            op_b_hi = py_reg;
            op_b_lo = cur_y_reg;
        end
        else
        begin
            op_a_hi = px_reg;
            op_a_lo = rd_x;
            op_b_hi = prev_y_reg;
            op_b_lo = rd_y;
        end
    end

    pip_mul #(
        .COORD_BITS(COORD_BITS)
    ) u_mul (
        .a_hi (op_a_hi),
        .a_lo (op_a_lo),
        .b_hi (op_b_hi),
        .b_lo (op_b_lo),
        .prod (prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vcount_reg    <= '0;
            bminx_reg     <= COORD_MIN;
            bminy_reg     <= COORD_MIN;
            bmaxx_reg     <= COORD_MAX;
            bmaxy_reg     <= COORD_MAX;
            n_reg         <= '0;
            i_reg         <= '0;
            pend_reg      <= 1'b0;
            inside_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_res_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pip_pkg::CFG_VERTEX_COUNT: vcount_reg <= cfg_data[CNT_BITS-1:0];
                    pip_pkg::CFG_BOX_MIN_X:    bminx_reg  <= cfg_data[COORD_BITS-1:0];
                    pip_pkg::CFG_BOX_MIN_Y:    bminy_reg  <= cfg_data[COORD_BITS-1:0];
                    pip_pkg::CFG_BOX_MAX_X:    bmaxx_reg  <= cfg_data[COORD_BITS-1:0];
                    pip_pkg::CFG_BOX_MAX_Y:    bmaxy_reg  <= cfg_data[COORD_BITS-1:0];
                    default: ;
                endcase
            end

            // the done state reloads the output register itself
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && (func == pip_pkg::FUNC_QUERY))
                    begin
                        n_reg     <= n_eff;
                        state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    inside_reg <= 1'b0;
                    pend_reg   <= 1'b0;
                    i_reg      <= '0;
                    if (box_pass && (n_reg != '0))
                    begin
                        state_reg <= ST_LOADJ;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_LOADJ:
                begin
                    state_reg <= ST_EDGE_A;
                end
                ST_EDGE_A:
                begin
                    if (pend_reg && toggle)
                    begin
                        inside_reg <= !inside_reg;
                    end
                    state_reg <= ST_EDGE_B;
                end
                ST_EDGE_B:
                begin
                    pend_reg <= 1'b1;
                    if (last_edge)
                    begin
                        state_reg <= ST_FINAL;
                    end
                    else
                    begin
                        i_reg     <= i_reg + IDX_BITS'(1);
                        state_reg <= ST_EDGE_A;
                    end
                end
                ST_FINAL:
                begin
                    if (toggle)
                    begin
                        inside_reg <= !inside_reg;
                    end
                    pend_reg  <= 1'b0;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_res_reg   <= inside_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (state_reg == ST_LOADJ)
        begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
        end
        if (state_reg == ST_EDGE_A)
        begin
            cur_x_reg <= rd_x;
            cur_y_reg <= rd_y;
            lhs_reg   <= prod;
            strad_reg <= (rd_y > py_reg) != (prev_y_reg > py_reg);
            dypos_reg <= (prev_y_reg > rd_y);
        end
        if (state_reg == ST_EDGE_B)
        begin
            rhs_reg    <= prod;
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
    end

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the done state");

    a_edge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EDGE_A || state_reg == ST_EDGE_B) |-> CNT_BITS'(i_reg) < n_reg)
        else $error("edge index beyond vertex count");

    a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOADJ |-> (n_reg != '0) && (32'(n_reg) <= MAX_VERTICES))
        else $error("walk started with bad vertex count");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EDGE_B && !last_edge) |=> state_reg == ST_EDGE_A && in_stall)
        else $error("edge walk broken");

endmodule

### bench/tb_point_in_polygon_test_core.sv
// Testbench for point_in_polygon_test_core: a directed table, then random phases.
// Each query is checked against a bench crossing-number model or a table result.
// Depends on pip_pkg and point_in_polygon_test_core.
`timescale 1ns / 1ps

module tb_point_in_polygon_test_core;

    localparam int NVERT = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 1850;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [2:0]         reg_idx;
        logic [15:0]        reg_val;
        logic               fn;
        logic [3:0]         slot;
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit                 has_res;
        bit                 res;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               func;
    logic [3:0]         vertex_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic               out_valid;
    logic               out_stall;
    logic               inside_res;

    // Shadow of the block's vertex store and registers
    logic signed [15:0] poly_x [NVERT];
    logic signed [15:0] poly_y [NVERT];
    logic [4:0]         vcount;
    logic signed [15:0] box_min_x, box_min_y, box_max_x, box_max_y;

    bit    expected_in_q [$];
    bit    exp_bit;
    row_t  stim_tab [$];
    int    errors = 0;
    int    item_cnt;
    bit    quiet;
    bit    hold_req;

    point_in_polygon_test_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .inside_res   (inside_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_500_000;
        $display("tb_point_in_polygon_test_core failed");
        $finish;
    end

    // Crossing-number test with exact products; ties on a crossing do not toggle.
    function automatic bit point_in_poly(logic signed [15:0] px, logic signed [15:0] py);
        longint x, y, xi, yi, xj, yj, dy, lhs, rhs;
        int     n, j;
        bit     in_flag;
        in_flag = 1'b0;
        x = px;
        y = py;
        if (px >= box_min_x && px <= box_max_x && py >= box_min_y && py <= box_max_y)
        begin
            n = (vcount > NVERT) ? NVERT : int'(vcount);
            j = n - 1;
            for (int i = 0; i < n; i++)
            begin
                xi = poly_x[i];
                yi = poly_y[i];
                xj = poly_x[j];
                yj = poly_y[j];
                if ((yi > y) != (yj > y))
                begin
                    dy = yj - yi;
                    lhs = (x - xi) * dy;
                    rhs = (xj - xi) * (y - yi);
                    if ((dy > 0) ? (lhs < rhs) : (lhs > rhs))
                        in_flag = ~in_flag;
                end
                j = i;
            end
        end
        return in_flag;
    endfunction

    function automatic int unsigned draw_wait();
        return quiet ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic int rnd_coord(int sc);
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, 1) ? 32767 : -32768;
        return int'($urandom_range(0, 2 * sc)) - sc;
    endfunction

    function automatic row_t cfg_step(logic [2:0] idx, int val);
        row_t r;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val[15:0];
        r.fn = pip_pkg::FUNC_WRITE;
        r.slot = '0;
        r.x = '0;
        r.y = '0;
        r.has_res = 1'b0;
        r.res = 1'b0;
        return r;
    endfunction

    function automatic row_t item_step(logic fn, int slot, int x, int y, bit has_res, bit res);
        row_t r;
        r.kind = ROW_ITEM;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.fn = fn;
        r.slot = slot[3:0];
        r.x = x[15:0];
        r.y = y[15:0];
        r.has_res = has_res;
        r.res = res;
        return r;
    endfunction

    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_item(logic fn, logic [3:0] slot, logic signed [15:0] x,
                             logic signed [15:0] y, bit has_res, bit res);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= fn;
        vertex_index <= slot;
        coord_x <= x;
        coord_y <= y;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (fn == pip_pkg::FUNC_QUERY)
            expected_in_q.push_back(has_res ? res : point_in_poly(x, y));
        else
        begin
            poly_x[slot] = x;
            poly_y[slot] = y;
        end
        item_cnt++;
        @(negedge clk);
    endtask

    // Drain: no input offered, every result back, then a further idle wait.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_in_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            pip_pkg::CFG_VERTEX_COUNT: vcount = val[4:0];
            pip_pkg::CFG_BOX_MIN_X:    box_min_x = val;
            pip_pkg::CFG_BOX_MIN_Y:    box_min_y = val;
            pip_pkg::CFG_BOX_MAX_X:    box_max_x = val;
            pip_pkg::CFG_BOX_MAX_Y:    box_max_y = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    function automatic int box_bound(int sc);
        case ($urandom_range(0, 3))
            0: return -32768;
            1: return 32767;
            default: return rnd_coord(sc);
        endcase
    endfunction

    // Receiver: random hold-off per transaction, one long hold on request
    initial
    begin
        int unsigned w;
        bit held;
        held = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                w = HOLD_CYCLES;
            end
            else
                w = draw_wait();
            if (w != 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_in_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual inside_res=%0b",
                         $time, inside_res);
            end
            else
            begin
                exp_bit = expected_in_q.pop_front();
                if (inside_res !== exp_bit)
                begin
                    errors++;
                    $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                             $time, exp_bit, inside_res);
                end
            end
        end
    end

    initial
    begin
        int phase, sc, ncl, nitems, kind, a, b, qx, qy, k;
        bit prev_cfg;

        item_cnt = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = pip_pkg::CFG_VERTEX_COUNT;
        cfg_data = '0;
        in_valid = 1'b0;
        func = pip_pkg::FUNC_WRITE;
        vertex_index = '0;
        coord_x = '0;
        coord_y = '0;
        vcount = '0;
        box_min_x = -16'sd32768;
        box_min_y = -16'sd32768;
        box_max_x = 16'sd32767;
        box_max_y = 16'sd32767;
        for (int i = 0; i < NVERT; i++)
        begin
            poly_x[i] = '0;
            poly_y[i] = '0;
        end

        // Empty polygon after reset, then a square with points on its edges,
        // box bounds, inverted boxes, a full-range triangle and a zero vertex count.
        stim_tab.push_back(item_step(pip_pkg::FUNC_QUERY, 0, 0, 0, 1, 0));
        stim_tab.push_back(item_step(pip_pkg::FUNC_QUERY, 0, -32768, 32767, 1, 0));
        stim_tab.push_back(item_step(pip_pkg::FUNC_QUERY, 9, 32767, -32768, 1, 0));
        stim_tab.push_back(item_step(pip_pkg::FUNC_WRITE, 0, -100, -100, 0, 0));
        stim_tab.push_back(item_step(pip_pkg::FUNC_WRITE, 1, 100, -100, 0, 0));
        stim_tab.push_back(item_step(pip_pkg::FUNC_WRITE, 2, 100, 100, 0, 0));
        stim_tab.push_back(item_step(pip_pkg::FUNC_WRITE, 3, -100, 100, 0, 0));
        stim_tab.push_back(cfg_step(pip_pkg::CFG_VERTEX_COUNT, 4));
        stim_tab.push_back(item_step(pip_pkg::FUNC_QUERY, 0, 0, 0, 0, 0));
        stim_tab.push_back(item_step(pip_pkg::FUNC_QUERY, 0, -100, 0, 0, 0));
        stim_tab.push_back(item_step(pip_pkg::FUNC_QUERY, 0, 100, 0, 0, 0));
        stim_tab.push_back(item_step(pip_pkg::FUNC_QUERY, 0, 0, -100, 0, 0));
        stim_tab.push_back(item_step(pip_pkg::FUNC_QUERY, 0, -100, -100, 0, 0));
        stim_tab.push_back(item_step(pip_pkg::FUNC_QUERY, 0, 101, 0, 0, 0));
        stim_tab.push_back(cfg_step(pip_pkg::CFG_BOX_MIN_X, -50));
        stim_tab.push_back(item_step(pip_pkg::FUNC_QUERY, 0, -50, 0, 0, 0));
        stim_tab.push_back(item_step(pip_pkg::FUNC_QUERY, 0, -51, 0, 1, 0));
        stim_tab.push_back(cfg_step(pip_pkg::CFG_BOX_MIN_X, 10));
        stim_tab.push_back(cfg_step(pip_pkg::CFG_BOX_MAX_X, -10));
        stim_tab.push_back(item_step(pip_pkg::FUNC_QUERY, 0, 0, 0, 1, 0));
        stim_tab.push_back(cfg_step(pip_pkg::CFG_BOX_MIN_X, -32768));
        stim_tab.push_back(cfg_step(pip_pkg::CFG_BOX_MAX_X, 32767));
        stim_tab.push_back(cfg_step(pip_pkg::CFG_BOX_MIN_Y, 1));
        stim_tab.push_back(cfg_step(pip_pkg::CFG_BOX_MAX_Y, -1));
        stim_tab.push_back(item_step(pip_pkg::FUNC_QUERY, 0, 0, 0, 1, 0));
        stim_tab.push_back(cfg_step(pip_pkg::CFG_BOX_MIN_Y, -32768));
        stim_tab.push_back(cfg_step(pip_pkg::CFG_BOX_MAX_Y, 32767));
        stim_tab.push_back(item_step(pip_pkg::FUNC_WRITE, 0, -32768, -32768, 0, 0));
        stim_tab.push_back(item_step(pip_pkg::FUNC_WRITE, 1, 32767, -32768, 0, 0));
        stim_tab.push_back(item_step(pip_pkg::FUNC_WRITE, 2, -32768, 32767, 0, 0));
        stim_tab.push_back(cfg_step(pip_pkg::CFG_VERTEX_COUNT, 3));
        stim_tab.push_back(item_step(pip_pkg::FUNC_QUERY, 0, -32768, -32768, 0, 0));
        stim_tab.push_back(item_step(pip_pkg::FUNC_QUERY, 0, 32767, 32767, 0, 0));
        stim_tab.push_back(item_step(pip_pkg::FUNC_QUERY, 0, -1, -1, 0, 0));
        stim_tab.push_back(item_step(pip_pkg::FUNC_QUERY, 0, 32767, -32768, 0, 0));
        stim_tab.push_back(cfg_step(pip_pkg::CFG_VERTEX_COUNT, 0));
        stim_tab.push_back(item_step(pip_pkg::FUNC_QUERY, 0, 5, 5, 1, 0));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        prev_cfg = 1'b1;
        foreach (stim_tab[r])
        begin
            if (stim_tab[r].kind == ROW_CFG)
            begin
                if (!prev_cfg)
                    settle();
                write_cfg(stim_tab[r].reg_idx, stim_tab[r].reg_val);
                prev_cfg = 1'b1;
            end
            else
            begin
                send_item(stim_tab[r].fn, stim_tab[r].slot, stim_tab[r].x, stim_tab[r].y,
                          stim_tab[r].has_res, stim_tab[r].res);
                prev_cfg = 1'b0;
            end
        end

        // Fill every slot so any count reads only written vertices
        item_cnt = 0;
        for (int i = 0; i < NVERT; i++)
            send_item(pip_pkg::FUNC_WRITE, i[3:0], 16'($urandom), 16'($urandom), 0, 0);

        phase = 0;
        while (item_cnt < RANDOM_ITEMS)
        begin
            settle();
            quiet = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 3))
                0: sc = 8;
                1: sc = 64;
                2: sc = 1024;
                default: sc = 32767;
            endcase

            // Count: over-range values, empty, full and ordinary sizes
            if (phase == 0)
                k = 31;
            else
                case ($urandom_range(0, 9))
                    0: k = 0;
                    1: k = $urandom_range(17, 31);
                    2: k = NVERT;
                    default: k = $urandom_range(1, NVERT);
                endcase
            ncl = (k > NVERT) ? NVERT : k;
            if ($urandom_range(0, 3) == 0)
                write_cfg(pip_pkg::CFG_VERTEX_COUNT, {11'($urandom), 5'(k)});
            else
                write_cfg(pip_pkg::CFG_VERTEX_COUNT, 16'(k));

            kind = $urandom_range(0, 4);
            for (int ax = 0; ax < 2; ax++)
            begin
                case (kind)
                    1:
                    begin
                        a = rnd_coord(sc);
                        b = rnd_coord(sc);
                        if (a > b)
                        begin
                            k = a;
                            a = b;
                            b = k;
                        end
                    end
                    2:
                    begin
                        a = box_bound(sc);
                        b = box_bound(sc);
                    end
                    3:
                    begin
                        // inverted on the x axis, ordered on the y axis
                        a = rnd_coord(sc);
                        b = rnd_coord(sc);
                        if ((a < b) == (ax == 0))
                        begin
                            k = a;
                            a = b;
                            b = k;
                        end
                    end
                    default:
                    begin
                        a = -32768;
                        b = 32767;
                    end
                endcase
                write_cfg(ax == 0 ? pip_pkg::CFG_BOX_MIN_X : pip_pkg::CFG_BOX_MIN_Y, 16'(a));
                write_cfg(ax == 0 ? pip_pkg::CFG_BOX_MAX_X : pip_pkg::CFG_BOX_MAX_Y, 16'(b));
            end

            if (phase == 2)
            begin
                quiet = 1'b1;
                hold_req = 1'b1;
            end

            for (int i = 0; i < ncl; i++)
                send_item(pip_pkg::FUNC_WRITE, i[3:0], 16'(rnd_coord(sc)),
                          16'(rnd_coord(sc)), 0, 0);

            nitems = (phase == 2) ? 80 : $urandom_range(20, 60);
            for (int n = 0; n < nitems; n++)
            begin
                if ($urandom_range(0, 99) < 15)
                    send_item(pip_pkg::FUNC_WRITE, 4'($urandom), 16'(rnd_coord(sc)),
                              16'(rnd_coord(sc)), 0, 0);
                else
                begin
                    qx = rnd_coord(sc);
                    qy = rnd_coord(sc);
                    if (ncl > 0)
                        case ($urandom_range(0, 6))
                            0:
                            begin
                                k = $urandom_range(0, ncl - 1);
                                qx = poly_x[k];
                                qy = poly_y[k];
                            end
                            1: qy = poly_y[$urandom_range(0, ncl - 1)];
                            2: qx = poly_x[$urandom_range(0, ncl - 1)];
                            default: ;
                        endcase
                    send_item(pip_pkg::FUNC_QUERY, 4'($urandom), 16'(qx), 16'(qy), 0, 0);
                end
            end
            phase++;
        end

        settle();
        if (errors == 0)
            $display("tb_point_in_polygon_test_core passed");
        else
            $display("tb_point_in_polygon_test_core failed");
        $finish;
    end

endmodule
